// File: rtl/hf2s_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hf2s_pkg: shared types and constants for the half-float to sRGB8 unit
// Holds the lane count, the stage control struct and the table of code
// thresholds. The table is built at elaboration from the exact sRGB decision
// points. Each entry from code 1 up is the smallest positive half pattern
// that encodes to at least that code; entry 0 is zero.
// ----------------------------------------------------------------------------
package hf2s_pkg;

    // lanes wired at the ports, and lanes actually computed
    localparam int LANE_COUNT = 3;
    localparam int CHANNELS   = 3;

    localparam int HALF_W     = 16;
    localparam int KEY_W      = HALF_W - 1;
    localparam int CODE_W     = 8;
    localparam int STAGES     = CODE_W;
    localparam int CODE_COUNT = 1 << CODE_W;
    localparam int BIG_W      = 320;

    // binary16 encoding of 1.0
    localparam logic [KEY_W-1:0] HALF_ONE = 15'h3C00;

    typedef logic [HALF_W-1:0] half_t;
    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [CODE_W-1:0] code_t;
    typedef logic [CODE_COUNT-1:0][KEY_W-1:0] thr_tab_t;

    // per-stage and output load strobes from the flow control
    typedef struct packed {
        logic [STAGES-1:0] stage_load;
        logic              out_load;
    } hf2s_ctl_t;

    // base ** times on a wide integer (elaboration only)
    function automatic logic [BIG_W-1:0] big_pow(input logic [BIG_W-1:0] base,
                                                 input int times);
        logic [BIG_W-1:0] acc;
        int               i;
        acc = BIG_W'(1);
        for (i = 0; i < times; i++) begin
            acc = acc * base;
        end
        return acc;
    endfunction

    // true when positive pattern h encodes to code k or above
    function automatic logic code_reaches(input key_t h, input int k,
                                          input logic [BIG_W-1:0] gain,
                                          input logic [BIG_W-1:0] rhs);
        logic [4:0]  ex;
        logic [9:0]  fr;
        logic [63:0] n;
        logic        reach;
        ex = h[14:10];
        fr = h[9:0];
        if (ex >= 5'd15) begin
            reach = 1'b1;
        end else begin
            if (ex == 5'd0) begin
                n = 64'(fr);
            end else begin
                n = 64'({1'b1, fr}) << (ex - 5'd1);
            end
            if (n == 64'd0) begin
                reach = 1'b0;
            end else if (n * 64'd10000000 <= (64'd31308 << 24)) begin
                // linear segment, round(3294.6 * n / 2^24) >= k
                reach = ((n * 64'd65892 + (64'd10 << 24)) >=
                         (64'(k) * (64'd20 << 24)));
            end else begin
                // curve segment, exact test n^5 * 10761^12 >= (40k+541)^12 * 2^120
                reach = ((big_pow(BIG_W'(n), 5) * gain) >= rhs);
            end
        end
        return reach;
    endfunction

    // smallest pattern reaching each code; entry 0 is zero
    function automatic thr_tab_t build_thresholds();
        thr_tab_t         tab;
        logic [BIG_W-1:0] gain;
        logic [BIG_W-1:0] rhs;
        key_t             lo;
        key_t             hi;
        key_t             mid;
        int               k;
        int               it;
        tab  = '0;
        gain = big_pow(BIG_W'(10761), 12);
        for (k = 1; k < CODE_COUNT; k++) begin
            rhs = big_pow(BIG_W'(40 * k + 541), 12) << 120;
            lo  = '0;
            hi  = HALF_ONE;
            for (it = 0; it < KEY_W; it++) begin
                if (lo < hi) begin
                    mid = (lo + hi) >> 1;
                    if (code_reaches(mid, k, gain, rhs)) begin
                        hi = mid;
                    end else begin
                        lo = mid + 1'b1;
                    end
                end
            end
            tab[k] = lo;
        end
        return tab;
    endfunction

    localparam thr_tab_t SRGB_THR = build_thresholds();

endpackage : hf2s_pkg
`default_nettype wire

// File: rtl/hf2s_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hf2s_lane: one color channel, half pattern to 8-bit sRGB code
// Binary search over the threshold table, one code bit per stage, MSB first.
// Negatives and NaN are folded to a zero key up front.
// ----------------------------------------------------------------------------
module hf2s_lane (
    input  wire                  clk,
    input  hf2s_pkg::half_t      half,
    input  hf2s_pkg::hf2s_ctl_t  ctl,
    output hf2s_pkg::code_t      code
);
    import hf2s_pkg::*;

    key_t  key_reg [STAGES-1];
    code_t lo_reg  [STAGES];
    code_t lo_next [STAGES];
    key_t  key_in;
    logic  is_nan;

    // sign or NaN -> key 0 (code 0); +inf and >= 1.0 land above the top threshold
    assign is_nan = (&half[14:10]) && (|half[9:0]);
    assign key_in = (half[15] || is_nan) ? '0 : half[KEY_W-1:0];

    // search stages
    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        localparam code_t STEP_BIT = code_t'(1) << (STAGES - 1 - s);
        key_t  key_cur;
        code_t lo_cur;
        code_t cand;

        if (s == 0) begin : g_first
            assign key_cur = key_in;
            assign lo_cur  = '0;
        end else begin : g_next
            assign key_cur = key_reg[s-1];
            assign lo_cur  = lo_reg[s-1];
        end

        assign cand       = lo_cur | STEP_BIT;
        assign lo_next[s] = (key_cur >= SRGB_THR[cand]) ? cand : lo_cur;

        always_ff @(posedge clk)
        begin
            if (ctl.stage_load[s])
            begin
                lo_reg[s] <= lo_next[s];
            end
        end

        // key is not needed past the last stage
        if (s < STAGES - 1) begin : g_key
            always_ff @(posedge clk)
            begin
                if (ctl.stage_load[s])
                begin
                    key_reg[s] <= key_cur;
                end
            end
        end
    end

    assign code = lo_reg[STAGES-1];

endmodule : hf2s_lane
`default_nettype wire

// File: rtl/hf2s_flow.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hf2s_flow: valid tracking and stall control for the lane pipeline
// One valid bit per search stage plus one for the output register. A stage
// takes a new request when it is empty or its contents move on, so bubbles
// are squeezed out while the output waits.
// ----------------------------------------------------------------------------
module hf2s_flow (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  pixel_valid,
    output logic                 pixel_ready,
    output logic                 srgb_valid,
    input  wire                  srgb_ready,
    output hf2s_pkg::hf2s_ctl_t  ctl
);
    import hf2s_pkg::*;

    // index STAGES is the output register
    logic [STAGES:0] valid_reg;
    logic [STAGES:0] valid_next;
    logic [STAGES:0] open;
    logic [STAGES:0] feed;

    // open chain from the output back to the input
    always_comb
    begin
        open[STAGES] = !valid_reg[STAGES] || srgb_ready;
        for (int s = STAGES - 1; s >= 0; s--) begin
            open[s] = !valid_reg[s] || open[s+1];
        end
    end

    // what arrives at each stage
    assign feed = {valid_reg[STAGES-1:0], pixel_valid};

    always_comb
    begin
        for (int s = 0; s <= STAGES; s++) begin
            valid_next[s] = open[s] ? feed[s] : valid_reg[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // load strobes only when a request actually moves in
    assign ctl.stage_load = open[STAGES-1:0] & feed[STAGES-1:0];
    assign ctl.out_load   = open[STAGES] & feed[STAGES];

    assign pixel_ready = open[0];
    assign srgb_valid  = valid_reg[STAGES];

endmodule : hf2s_flow
`default_nettype wire

// File: rtl/half_float_to_srgb8_pixel_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// half_float_to_srgb8_pixel_unit: linear half-float texel to 8-bit sRGB
// Three channel lanes run side by side; the output register merges their
// codes into one result.
//
//   channel | signals                                   | role
//   --------+-------------------------------------------+-----------------
//   pixel   | pixel_valid/ready, red/green/blue_half    | texel request in
//   srgb    | srgb_valid/ready,  red/green/blue_srgb    | sRGB codes out
//
// One texel per clock sustained while srgb_ready is high; a request passes
// one register per code bit of the table search, then the output register.
// Reset clears all valid bits; the pipeline is empty and ready afterwards.
// While srgb_ready is low, requests still enter until every stage is full.
// ----------------------------------------------------------------------------
module half_float_to_srgb8_pixel_unit (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              pixel_valid,
    output logic             pixel_ready,
    input  hf2s_pkg::half_t  red_half,
    input  hf2s_pkg::half_t  green_half,
    input  hf2s_pkg::half_t  blue_half,
    output logic             srgb_valid,
    input  wire              srgb_ready,
    output hf2s_pkg::code_t  red_srgb,
    output hf2s_pkg::code_t  green_srgb,
    output hf2s_pkg::code_t  blue_srgb
);
    import hf2s_pkg::*;

    hf2s_ctl_t ctl;
    half_t     lane_half [LANE_COUNT];
    code_t     lane_code [LANE_COUNT];
    code_t     red_srgb_reg;
    code_t     green_srgb_reg;
    code_t     blue_srgb_reg;

    // flow control
    hf2s_flow u_flow (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .srgb_valid  (srgb_valid),
        .srgb_ready  (srgb_ready),
        .ctl         (ctl)
    );

    assign lane_half[0] = red_half;
    assign lane_half[1] = green_half;
    assign lane_half[2] = blue_half;

    // channel lanes; lanes past CHANNELS read as zero
    for (genvar c = 0; c < LANE_COUNT; c++) begin : g_lane
        if (c < CHANNELS) begin : g_on
            hf2s_lane u_lane (
                .clk  (clk),
                .half (lane_half[c]),
                .ctl  (ctl),
                .code (lane_code[c])
            );
        end else begin : g_off
            assign lane_code[c] = '0;
        end
    end

    // merge into the output register
    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            red_srgb_reg   <= lane_code[0];
            green_srgb_reg <= lane_code[1];
            blue_srgb_reg  <= lane_code[2];
        end
    end

    assign red_srgb   = red_srgb_reg;
    assign green_srgb = green_srgb_reg;
    assign blue_srgb  = blue_srgb_reg;

endmodule : half_float_to_srgb8_pixel_unit
`default_nettype wire

// File: rtl/hf2s_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hf2s_checker: port-level checks for the half-float to sRGB8 unit
// Watches the two handshakes and the pipeline's flow behavior.
// ----------------------------------------------------------------------------
module hf2s_checker (
    input wire              clk,
    input wire              rst_n,
    input wire              pixel_valid,
    input wire              pixel_ready,
    input wire              srgb_valid,
    input wire              srgb_ready,
    input hf2s_pkg::code_t  red_srgb,
    input hf2s_pkg::code_t  green_srgb,
    input hf2s_pkg::code_t  blue_srgb
);
    import hf2s_pkg::*;

    // a held result keeps its codes
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        srgb_valid && !srgb_ready |=> srgb_valid && $stable(red_srgb) &&
        $stable(green_srgb) && $stable(blue_srgb))
        else $error("result dropped or changed while stalled");

    // a free-running output never back-pressures the input
    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        srgb_ready |-> pixel_ready)
        else $error("input stalled with output open");

    // empty output register means the pipeline can take a request
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !srgb_valid |-> pixel_ready)
        else $error("input stalled with output empty");

    // a fresh result follows an accepted request through every search stage and the output register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        srgb_valid && !$past(srgb_valid) |-> $past(pixel_valid && pixel_ready, STAGES + 1))
        else $error("result appeared without a matching request");

endmodule : hf2s_checker

bind half_float_to_srgb8_pixel_unit hf2s_checker u_hf2s_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .srgb_valid  (srgb_valid),
    .srgb_ready  (srgb_ready),
    .red_srgb    (red_srgb),
    .green_srgb  (green_srgb),
    .blue_srgb   (blue_srgb)
);
`default_nettype wire

// File: bench/half_float_to_srgb8_pixel_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// half_float_to_srgb8_pixel_unit_tb: self-checking bench for the sRGB8 unit
// Texel requests carrying three binary16 patterns go in over valid/ready.
// Each accepted request is predicted with an exact integer sRGB encoder. The
// codes coming out are checked in order against those predictions. Directed
// requests cover zeros, signs, inf, NaN, subnormals, the linear/curve boundary
// and values around one. Random requests follow under three idle settings.
// ----------------------------------------------------------------------------
module half_float_to_srgb8_pixel_unit_tb;

    import hf2s_pkg::*;

    localparam int RESET_CYCLES = 6;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT = 400000;

    // binary16 patterns used by the directed requests
    localparam half_t H_POS_ZERO = 16'h0000;
    localparam half_t H_NEG_ZERO = 16'h8000;
    localparam half_t H_POS_INF = 16'h7C00;
    localparam half_t H_NEG_INF = 16'hFC00;
    localparam half_t H_QNAN = 16'h7E00;
    localparam half_t H_NEG_QNAN = 16'hFE00;
    localparam half_t H_SNAN = 16'h7C01;
    localparam half_t H_ALL_ONES = 16'hFFFF;
    localparam half_t H_MAX_FINITE = 16'h7BFF;
    localparam half_t H_NEG_MAX = 16'hFBFF;
    localparam half_t H_ONE = 16'h3C00;
    localparam half_t H_BELOW_ONE = 16'h3BFF;
    localparam half_t H_HALF = 16'h3800;
    localparam half_t H_MIN_SUB = 16'h0001;
    localparam half_t H_MAX_SUB = 16'h03FF;
    localparam half_t H_MIN_NORM = 16'h0400;
    localparam half_t H_LIN_TOP = 16'h1A69;   // last pattern on the linear segment
    localparam half_t H_CURVE_LOW = 16'h1A6A; // first pattern on the curve

    typedef struct packed {
        code_t red;
        code_t green;
        code_t blue;
    } srgb_pixel_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  pixel_valid = 1'b0;
    logic  pixel_ready;
    half_t red_half = '0;
    half_t green_half = '0;
    half_t blue_half = '0;
    logic  srgb_valid;
    logic  srgb_ready = 1'b0;
    code_t red_srgb;
    code_t green_srgb;
    code_t blue_srgb;

    srgb_pixel_t srgb_expected_q[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;

    half_float_to_srgb8_pixel_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .red_half    (red_half),
        .green_half  (green_half),
        .blue_half   (blue_half),
        .srgb_valid  (srgb_valid),
        .srgb_ready  (srgb_ready),
        .red_srgb    (red_srgb),
        .green_srgb  (green_srgb),
        .blue_srgb   (blue_srgb)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("half_float_to_srgb8_pixel_unit_tb NOT OK");
            $finish;
        end
    end

    // exact sRGB code of one binary16 pattern
    function automatic code_t srgb_code_of(input half_t h);
        logic [4:0]   ex;
        logic [9:0]   fr;
        logic [63:0]  n;
        logic [319:0] lhs;
        logic [319:0] rhs;
        logic [319:0] step_val;
        int           lo;
        int           hi;
        int           mid;
        int           i;
        ex = h[14:10];
        fr = h[9:0];
        // NaN, then negatives, then one and above
        if (ex == 5'h1F && fr != 10'd0)
            return '0;
        if (h[15])
            return '0;
        if (ex >= 5'd15)
            return 8'd255;
        if (ex == 5'd0)
            n = 64'(fr);
        else
            n = 64'({1'b1, fr}) << (ex - 5'd1);
        if (n == 64'd0)
            return '0;
        // linear segment: round(3294.6 * n / 2^24)
        if (n * 64'd10000000 <= (64'd31308 << 24))
            return code_t'((n * 64'd65892 + (64'd10 << 24)) / (64'd20 << 24));
        // curve: largest k with n^5 * 10761^12 >= (40k+541)^12 * 2^120
        lhs = 320'd1;
        for (i = 0; i < 5; i++)
            lhs = lhs * 320'(n);
        for (i = 0; i < 12; i++)
            lhs = lhs * 320'd10761;
        lo = 0;
        hi = 255;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            step_val = 320'(40 * mid + 541);
            rhs = 320'd1;
            for (i = 0; i < 12; i++)
                rhs = rhs * step_val;
            rhs = rhs << 120;
            if (lhs >= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return code_t'(lo);
    endfunction

    task automatic check_field(input string name, input code_t want, input code_t got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // result checking first, then prediction of the accepted request
    always @(posedge clk)
    begin
        srgb_pixel_t want;
        srgb_pixel_t pred;
        if (rst_n)
        begin
            if (srgb_valid && srgb_ready)
            begin
                if (srgb_expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %0d %0d %0d",
                             $time, red_srgb, green_srgb, blue_srgb);
                    mismatch_count++;
                end
                else
                begin
                    want = srgb_expected_q.pop_front();
                    check_field("red_srgb", want.red, red_srgb);
                    check_field("green_srgb", want.green, green_srgb);
                    check_field("blue_srgb", want.blue, blue_srgb);
                end
            end
            if (pixel_valid && pixel_ready)
            begin
                pred.red = (CHANNELS > 0) ? srgb_code_of(red_half) : '0;
                pred.green = (CHANNELS > 1) ? srgb_code_of(green_half) : '0;
                pred.blue = (CHANNELS > 2) ? srgb_code_of(blue_half) : '0;
                srgb_expected_q.push_back(pred);
            end
        end
    end

    // output side back-pressure
    always @(negedge clk)
    begin
        srgb_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // one texel request, with a random lead-in gap
    task automatic send_pixel(input half_t r, input half_t g, input half_t b);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            pixel_valid <= 1'b0;
            @(negedge clk);
        end
        pixel_valid <= 1'b1;
        red_half <= r;
        green_half <= g;
        blue_half <= b;
        do
            @(posedge clk);
        while (!pixel_ready);
    endtask

    // stop sending and wait until every pending result is out
    task automatic drain_pipeline();
        @(negedge clk);
        pixel_valid <= 1'b0;
        while (srgb_expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic half_t random_half();
        half_t h;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: h = half_t'($urandom_range(0, 16'h3BFF));
            5, 6: h = half_t'($urandom_range(0, 16'h1C00));  // subnormals, linear segment and the start of the curve
            7: h = half_t'($urandom_range(16'h3B00, 16'h3C40)); // around one
            8: h = half_t'($urandom());
            default: h = H_POS_INF | (half_t'($urandom()) & 16'h83FF); // inf / NaN
        endcase
        return h;
    endfunction

    task automatic test_signs_and_specials();
        send_pixel(H_POS_ZERO, H_NEG_ZERO, H_POS_INF);
        send_pixel(H_NEG_INF, H_QNAN, H_NEG_QNAN);
        send_pixel(H_SNAN, H_ALL_ONES, H_MAX_FINITE);
        send_pixel(H_NEG_MAX, H_ONE, H_POS_ZERO);
        send_pixel(H_POS_INF, H_SNAN, H_NEG_ZERO);
    endtask

    task automatic test_subnormals();
        send_pixel(H_MIN_SUB, H_MAX_SUB, H_MIN_NORM);
        send_pixel(16'h0200, H_MIN_SUB, H_MAX_SUB);
        send_pixel(H_MIN_NORM, 16'h0155, H_MIN_SUB);
    endtask

    task automatic test_segment_boundary();
        send_pixel(H_LIN_TOP, H_CURVE_LOW, H_LIN_TOP - 16'd1);
        send_pixel(H_CURVE_LOW, H_LIN_TOP, H_CURVE_LOW + 16'd1);
        send_pixel(H_CURVE_LOW + 16'd1, H_LIN_TOP - 16'd1, H_LIN_TOP);
    endtask

    task automatic test_near_one();
        send_pixel(H_BELOW_ONE, H_ONE, H_ONE + 16'd1);
        send_pixel(H_HALF, H_BELOW_ONE - 16'd1, H_BELOW_ONE);
        send_pixel(H_MAX_FINITE, H_BELOW_ONE, H_ONE);
        send_pixel(H_ONE, H_HALF, H_BELOW_ONE);
    endtask

    task automatic test_random_pixels(input int count, input int tx_pct, input int rx_pct);
        int i;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (i = 0; i < count; i++)
            send_pixel(random_half(), random_half(), random_half());
        drain_pipeline();
    endtask

    // test sequence
    initial
    begin
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_signs_and_specials();
        test_subnormals();
        test_segment_boundary();
        test_near_one();
        drain_pipeline();

        test_random_pixels(150, 26, 82);
        test_random_pixels(150, 82, 26);
        test_random_pixels(150, 0, 0);

        if (mismatch_count == 0)
            $display("half_float_to_srgb8_pixel_unit_tb OK");
        else
            $display("half_float_to_srgb8_pixel_unit_tb NOT OK");
        $finish;
    end

endmodule

// File: files.f
rtl/hf2s_pkg.sv
rtl/hf2s_lane.sv
rtl/hf2s_flow.sv
rtl/half_float_to_srgb8_pixel_unit.sv
rtl/hf2s_checker.sv
bench/half_float_to_srgb8_pixel_unit_tb.sv
